// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define F32D_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define F32D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/f32d_pkg.sv =====
// ----------------------------------------------------------------------------
// f32d_pkg
// types and constants of the single-precision divider
// ----------------------------------------------------------------------------
package f32d_pkg;

    localparam int unsigned FRAC_BITS = 23;
    localparam int unsigned MANT_BITS = FRAC_BITS + 1;
    localparam int unsigned EXP_BITS  = 8;
    localparam int unsigned XEXP_BITS = 11;

    localparam logic [31:0]          DEFAULT_NAN = 32'h7FC0_0001;
    localparam logic [EXP_BITS-1:0]  EXP_ALL_ONES = 8'hFF;
    localparam logic [XEXP_BITS-1:0] EXP_OFFSET  = 11'd125;
    localparam logic [XEXP_BITS-1:0] EXP_OVF     = 11'd255;
    localparam logic [XEXP_BITS-1:0] EXP_UFL     = 11'h7E9;  // -23
    localparam logic [31:0]          ROUND_INC   = 32'd64;

    typedef struct packed {
        logic                 sign;
        logic                 nan;
        logic                 inf;
        logic                 zero;
        logic [EXP_BITS-1:0]  expo;
        logic [MANT_BITS-1:0] mant;
    } t_operand;

endpackage

// ===== rtl/core/f32d_classify.sv =====
// ----------------------------------------------------------------------------
// f32d_classify
// decodes one single-precision operand into class flags and significand
// ----------------------------------------------------------------------------
module f32d_classify (
    input  logic [31:0]        i_bits,
    output f32d_pkg::t_operand o_op
);
    import f32d_pkg::*;

    logic [EXP_BITS-1:0]  w_exp;
    logic [FRAC_BITS-1:0] w_frac;

    assign w_exp  = i_bits[30:23];
    assign w_frac = i_bits[22:0];

    always_comb begin
        o_op.sign = i_bits[31];
        o_op.expo = w_exp;
        o_op.nan  = (w_exp == EXP_ALL_ONES) && (w_frac != '0);
        o_op.inf  = (w_exp == EXP_ALL_ONES) && (w_frac == '0);
        o_op.zero = (i_bits[30:0] == '0);
        // subnormals start one place up, normals get the hidden bit
        if (w_exp == '0) begin
            o_op.mant = {w_frac, 1'b0};
        end else begin
            o_op.mant = {1'b1, w_frac};
        end
    end

endmodule

// ===== rtl/core/float32_divider_unit.sv =====
// ----------------------------------------------------------------------------
// float32_divider_unit
// single-precision divider, radix-2 restoring, one quotient bit per cycle
// ----------------------------------------------------------------------------
// usage:
//   input channel carries dividend and divisor; a beat is taken when i_valid
//   is high and o_stall is low. output channel carries the quotient; a beat
//   leaves when o_valid is high and i_stall is low.
//   one operation is in flight at a time; o_stall stays high from accept
//   until the result beat is taken.
// sequence:
//   special operands (nan, infinity, zero) give a result in the cycle after
//   accept. other operands go through a normalize check, divide iterations
//   that give one bit each of the 31-bit quotient, a round and a pack step.
//   normalize shifts both significands together, one place per leading zero
//   of the more subnormal operand (up to 22 places), and pack shifts a
//   subnormal result right one place per bit of denormalization (up to 23).
//   a new operation is taken only after the last result beat has left.
// reset:
//   synchronous reset returns the unit to idle and drops o_valid.
// stall:
//   while i_stall is high a pending quotient beat holds and no input is taken.
// ----------------------------------------------------------------------------
module float32_divider_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_quotient
);
    import f32d_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_DIV,
        S_ROUND,
        S_PACK,
        S_DONE
    } t_state;

    t_operand w_a;
    t_operand w_b;

    f32d_classify u_cls_a (.i_bits(i_dividend), .o_op(w_a));
    f32d_classify u_cls_b (.i_bits(i_divisor),  .o_op(w_b));

    t_state                      r_state, n_state;
    logic [MANT_BITS-1:0]        r_am, n_am;
    logic [MANT_BITS-1:0]        r_bm, n_bm;
    logic signed [XEXP_BITS-1:0] r_ae, n_ae;
    logic signed [XEXP_BITS-1:0] r_be, n_be;
    logic signed [XEXP_BITS-1:0] r_e, n_e;
    logic [MANT_BITS:0]          r_rem, n_rem;
    logic [30:0]                 r_q, n_q;
    logic [31:0]                 r_s, n_s;
    logic [4:0]                  r_cnt, n_cnt;
    logic                        r_sign, n_sign;
    logic                        r_uf, n_uf;
    logic [31:0]                 r_quot, n_quot;

    logic [MANT_BITS+1:0] w_diff;
    logic                 w_bit;
    logic [MANT_BITS:0]   w_rr;
    logic [31:0]          w_sum;
    logic                 w_ge;

    assign w_diff = {1'b0, r_rem} - {2'b00, r_bm};
    assign w_bit  = ~w_diff[MANT_BITS+1];
    assign w_rr   = w_bit ? w_diff[MANT_BITS:0] : r_rem;
    assign w_sum  = {1'b0, r_q} + ROUND_INC;
    assign w_ge   = (r_am >= r_bm);

    always_comb begin
        n_state = r_state;
        n_am    = r_am;
        n_bm    = r_bm;
        n_ae    = r_ae;
        n_be    = r_be;
        n_e     = r_e;
        n_rem   = r_rem;
        n_q     = r_q;
        n_s     = r_s;
        n_cnt   = r_cnt;
        n_sign  = r_sign;
        n_uf    = r_uf;
        n_quot  = r_quot;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sign  = w_a.sign ^ w_b.sign;
                    n_state = S_DONE;
                    n_am    = w_a.mant;
                    n_bm    = w_b.mant;
                    n_ae    = signed'({3'b000, w_a.expo});
                    n_be    = signed'({3'b000, w_b.expo});
                    n_uf    = 1'b0;
                    if (w_a.nan) begin
                        n_quot = i_dividend;
                    end else if (w_b.nan) begin
                        n_quot = i_divisor;
                    end else if (w_a.inf) begin
                        n_quot = w_b.inf ? DEFAULT_NAN
                                         : {w_a.sign ^ w_b.sign, EXP_ALL_ONES, 23'd0};
                    end else if (w_b.inf) begin
                        n_quot = {w_a.sign ^ w_b.sign, 31'd0};
                    end else if (w_b.zero) begin
                        n_quot = w_a.zero ? DEFAULT_NAN
                                          : {w_a.sign ^ w_b.sign, EXP_ALL_ONES, 23'd0};
                    end else if (w_a.zero) begin
                        n_quot = {w_a.sign ^ w_b.sign, 31'd0};
                    end else begin
                        n_state = S_NORM;
                    end
                end
            end
            S_NORM: begin
                if (r_am[MANT_BITS-1] && r_bm[MANT_BITS-1]) begin
                    n_e     = r_ae - r_be + signed'(EXP_OFFSET)
                              + signed'({{(XEXP_BITS-1){1'b0}}, w_ge});
                    n_rem   = w_ge ? {1'b0, r_am} : {r_am, 1'b0};
                    n_q     = '0;
                    n_cnt   = 5'd30;
                    n_state = S_DIV;
                end else begin
                    if (!r_am[MANT_BITS-1]) begin
                        n_am = {r_am[MANT_BITS-2:0], 1'b0};
                        n_ae = r_ae - 11'sd1;
                    end
                    if (!r_bm[MANT_BITS-1]) begin
                        n_bm = {r_bm[MANT_BITS-2:0], 1'b0};
                        n_be = r_be - 11'sd1;
                    end
                end
            end
            S_DIV: begin
                n_rem = {w_rr[MANT_BITS-1:0], 1'b0};
                n_q   = {r_q[29:0], w_bit};
                if (r_cnt == '0) begin
                    n_state = S_ROUND;
                end else begin
                    n_cnt = r_cnt - 5'd1;
                end
            end
            S_ROUND: begin
                if (!w_sum[31]) begin
                    n_s = {1'b0, w_sum[31:1]};
                    n_e = r_e + 11'sd1;
                end else begin
                    n_s = w_sum;
                end
                n_state = S_PACK;
            end
            S_PACK: begin
                if (r_e >= signed'(EXP_OVF)) begin
                    n_quot  = {r_sign, EXP_ALL_ONES, 23'd0};
                    n_state = S_DONE;
                end else if (r_e < signed'(EXP_UFL)) begin
                    n_quot  = {r_sign, 31'd0};
                    n_state = S_DONE;
                end else if (r_e < 11'sd0) begin
                    n_s  = {1'b0, r_s[31:1]};
                    n_e  = r_e + 11'sd1;
                    n_uf = 1'b1;
                end else if (r_uf) begin
                    n_quot  = {r_sign, 8'd0, r_s[29:7]};
                    n_state = S_DONE;
                end else begin
                    n_quot  = {r_sign, r_e[EXP_BITS-1:0], r_s[28:6]};
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_am   <= n_am;
        r_bm   <= n_bm;
        r_ae   <= n_ae;
        r_be   <= n_be;
        r_e    <= n_e;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_s    <= n_s;
        r_cnt  <= n_cnt;
        r_sign <= n_sign;
        r_uf   <= n_uf;
        r_quot <= n_quot;
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = (r_state == S_DONE);
    assign o_quotient = r_quot;

endmodule

// ===== rtl/core/f32d_checker.sv =====
// ----------------------------------------------------------------------------
// f32d_checker
// port-level checks of the single-precision divider, bound to float32_divider_unit
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module f32d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [31:0] i_dividend,
    input logic [31:0] i_divisor,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_quotient
);

    // result beat waits until taken
    `F32D_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_quotient), "quotient beat dropped while stalled")

    // one operation in flight: no input while a result is pending
    `F32D_ASSERT(a_busy_out, i_clk, i_rst_n, o_valid |-> o_stall, "input open while result pending")

    // an accepted beat closes the input side
    `F32D_ASSERT(a_busy_acc, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall, "input open right after accept")

    // a result beat leaving reopens the input side
    `F32D_ASSERT(a_reopen, i_clk, i_rst_n, o_valid && !i_stall |=> !o_stall && !o_valid, "unit not idle after result beat")

    // reset clears the output channel
    `F32D_ASSERT_ALWAYS(a_rst_clr, i_clk, !i_rst_n |=> !o_valid && !o_stall, "output valid after reset")

endmodule

bind float32_divider_unit f32d_checker u_f32d_checker (.*);

// ===== tb/tb_float32_divider_unit.sv =====
// ----------------------------------------------------------------------------
// tb_float32_divider_unit
// checks the single-precision divider against a bit-exact quotient predictor,
// with directed special operands, random operand classes and random idling
// ----------------------------------------------------------------------------
module tb_float32_divider_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_dividend;
    logic [31:0] i_divisor;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_quotient;

    logic [31:0] quotient_queue[$];
    int          error_count;
    int          idle_cycles;
    int          send_gap_pct;
    int          recv_gap_pct;
    bit          hold_off;
    bit          timed_out;

    float32_divider_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_quotient (o_quotient)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] pack_f32(logic s, logic [7:0] e, logic [22:0] f);
        return {s, e, f};
    endfunction

    function automatic logic [31:0] predict_quotient(logic [31:0] a, logic [31:0] b);
        logic        s;
        logic [7:0]  ae, be;
        logic [22:0] af, bf;
        int          aexp, bexp, cexp;
        logic [63:0] afrac, bfrac, cfrac, num;
        s  = a[31] ^ b[31];
        ae = a[30:23];
        be = b[30:23];
        af = a[22:0];
        bf = b[22:0];
        if (ae == 8'hFF && af != 0) return a;
        if (be == 8'hFF && bf != 0) return b;
        if (ae == 8'hFF) begin
            if (be == 8'hFF) return f32d_pkg::DEFAULT_NAN;
            return pack_f32(s, 8'hFF, 23'd0);
        end
        if (be == 8'hFF) return pack_f32(s, 8'd0, 23'd0);
        if (b[30:0] == 0) begin
            if (a[30:0] == 0) return f32d_pkg::DEFAULT_NAN;
            return pack_f32(s, 8'hFF, 23'd0);
        end
        if (a[30:0] == 0) return pack_f32(s, 8'd0, 23'd0);
        afrac = 64'(af);
        bfrac = 64'(bf);
        aexp  = ae;
        bexp  = be;
        if (aexp == 0) begin
            afrac = afrac << 1;
            while (afrac[23] == 1'b0) begin
                afrac = afrac << 1;
                aexp--;
            end
        end
        if (bexp == 0) begin
            bfrac = bfrac << 1;
            while (bfrac[23] == 1'b0) begin
                bfrac = bfrac << 1;
                bexp--;
            end
        end
        afrac = (afrac | 64'h80_0000) << 8;
        bfrac = (bfrac | 64'h80_0000) << 9;
        if (bfrac <= (afrac << 1)) begin
            afrac = afrac >> 1;
            aexp++;
        end
        cexp  = aexp - bexp + 125;
        num   = afrac << 32;
        cfrac = num / bfrac;
        if (cfrac[5:0] == 0) cfrac[0] = (bfrac * cfrac != num);
        while (cexp > 0 && cfrac != 0 && cfrac[30] == 1'b0) begin
            cexp--;
            cfrac = cfrac << 1;
        end
        cfrac = cfrac + 64'd64;
        if (cfrac[30]) begin
            cexp++;
            cfrac = cfrac >> 1;
        end
        if (cexp >= 255) return pack_f32(s, 8'hFF, 23'd0);
        if (cexp < 0) begin
            if (cexp + 23 < 0) return pack_f32(s, 8'd0, 23'd0);
            cfrac = cfrac >> 1;
            while (cexp < 0) begin
                cexp++;
                cfrac = cfrac >> 1;
            end
            return pack_f32(s, 8'd0, cfrac[28:6]);
        end
        return pack_f32(s, 8'(cexp), cfrac[28:6]);
    endfunction

    task automatic send_operands(logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_gap_pct) @(posedge i_clk);
        i_valid    <= 1'b1;
        i_dividend <= a;
        i_divisor  <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        quotient_queue.push_back(predict_quotient(a, b));
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // random operand from a spread of classes
    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0: v[30:23] = 8'd0;
            1: v[30:0]  = 31'd0;
            2: v[30:23] = 8'hFF;
            3: v[30:23] = 8'($urandom_range(1, 3));
            4: v[30:23] = 8'($urandom_range(250, 254));
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_special_operands();
        logic [31:0] vals[10];
        vals = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_1234, 32'hFFFF_FFFF, 32'h0000_0001, 32'h007F_FFFF,
                 32'h3F80_0000, 32'h7F7F_FFFF};
        for (int i = 0; i < 10; i++) send_operands(vals[i], vals[(i * 3 + 1) % 10]);
        send_operands(32'h7F80_0000, 32'hFF80_0000);
        send_operands(32'h0000_0000, 32'h8000_0000);
        send_operands(32'h7F7F_FFFF, 32'h0000_0001);
        send_operands(32'h0080_0000, 32'h7F7F_FFFF);
        send_operands(32'h0000_0001, 32'h3F80_0000);
        send_operands(32'h3F80_0000, 32'h4040_0000);
        send_operands(32'h7F80_0001, 32'h7FC0_0000);
        send_operands(32'h4000_0000, 32'h0000_0000);
        send_operands(32'h0000_0001, 32'h7F7F_FFFF);
    endtask

    task automatic test_random_operands(int count);
        for (int i = 0; i < count; i++) send_operands(random_operand(), random_operand());
    endtask

    task automatic test_backpressure();
        hold_off <= 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            test_random_operands(4);
        join
    endtask

    task automatic wait_drained();
        while (quotient_queue.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= hold_off || ($urandom_range(99) < recv_gap_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (quotient_queue.size() == 0) begin
                $error("unexpected quotient beat %h", o_quotient);
                error_count++;
            end else begin
                if (o_quotient !== quotient_queue[0]) begin
                    $error("quotient expected %h actual %h", quotient_queue[0], o_quotient);
                    error_count++;
                end
                void'(quotient_queue.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_dividend   = '0;
        i_divisor    = '0;
        hold_off     = 1'b0;
        send_gap_pct = 15;
        recv_gap_pct = 77;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_operands();
        test_backpressure();
        test_random_operands(560);
        send_gap_pct = 77;
        recv_gap_pct = 15;
        test_random_operands(560);
        send_gap_pct = 0;
        recv_gap_pct = 0;
        test_random_operands(560);
        wait_drained();
        if (error_count == 0 && quotient_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
